@@ src/lbcc_pkg.sv @@
// ---------------------------------------------------------------------------
// lbcc_pkg
// Shared types and constants of the bouncing-window color cycler.
// ---------------------------------------------------------------------------
package lbcc_pkg;

   localparam int MAX_PIXELS    = 1024;
   localparam int DEFAULT_LEVEL = 255;

   localparam int CFG_WIDTH   = 11;
   localparam int INDEX_WIDTH = 10;
   localparam int LEVEL_WIDTH = 8;

   // commands
   localparam logic [1:0] CMD_SELECT_COLOR = 2'd0;
   localparam logic [1:0] CMD_SELECT_LEVEL = 2'd1;
   localparam logic [1:0] CMD_TICK         = 2'd2;
   localparam logic [1:0] CMD_IGNORED      = 2'd3;

   // register indexes
   localparam logic CSR_STRIP_LENGTH  = 1'b0;
   localparam logic CSR_WINDOW_LENGTH = 1'b1;

   typedef struct packed {
      logic [1:0] command;
      logic [2:0] argument;
   } req_type;

   typedef struct packed {
      logic                   write_valid;
      logic [INDEX_WIDTH-1:0] pixel_index;
      logic [LEVEL_WIDTH-1:0] red_out;
      logic [LEVEL_WIDTH-1:0] green_out;
      logic [LEVEL_WIDTH-1:0] blue_out;
      logic                   show_frame;
      logic                   status;
   } rsp_type;

   typedef struct packed {
      logic [CFG_WIDTH-1:0] strip_length;
      logic [CFG_WIDTH-1:0] window_length;
   } cfg_type;

   // results handed to the output queue in the same cycle
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } push_type;

   // free slots after this cycle's pop
   typedef struct packed {
      logic [1:0] room;
   } queue_status_type;

endpackage

@@ src/lbcc_rsp_queue.sv @@
// ---------------------------------------------------------------------------
// lbcc_rsp_queue
// Two-entry result queue; takes up to two items a cycle as room allows, gives one while the receiver is ready.
// ---------------------------------------------------------------------------
module lbcc_rsp_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  lbcc_pkg::push_type         push,
   output lbcc_pkg::queue_status_type status,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output lbcc_pkg::rsp_type          rsp_item
);

   logic [1:0]        count_ff, count_in;
   lbcc_pkg::rsp_type slot0_ff, slot0_in;
   lbcc_pkg::rsp_type slot1_ff, slot1_in;
   logic              pop;
   logic [1:0]        remain;

   assign rsp_valid   = (count_ff != 2'd0);
   assign rsp_item    = slot0_ff;
   assign pop         = rsp_valid && rsp_ready;
   assign remain      = count_ff - {1'b0, pop};
   assign status.room = 2'd2 - remain;

   always_comb begin
      slot0_in = pop ? slot1_ff : slot0_ff;
      slot1_in = slot1_ff;
      count_in = remain + push.count;
      unique case (remain)
         2'd0: begin
            slot0_in = push.first;
            slot1_in = push.second;
         end
         2'd1: begin
            slot1_in = push.first;
         end
         default: begin
            // full: hold
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2)
      else $error("result queue over capacity");

   a_full_holds: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd2 && !pop) |=> (count_ff == 2'd2 && $stable(slot0_ff)))
      else $error("full queue changed without a pop");

endmodule

@@ src/lbcc_engine.sv @@
// ---------------------------------------------------------------------------
// lbcc_engine
// Input register, color and sweep state, and the per-item result logic.
// ---------------------------------------------------------------------------
module lbcc_engine (
   input  logic                       clock,
   input  logic                       reset,
   input  lbcc_pkg::cfg_type          cfg,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  lbcc_pkg::req_type          req_item,
   input  lbcc_pkg::queue_status_type queue_status,
   output lbcc_pkg::push_type         push
);

   localparam int LW = lbcc_pkg::LEVEL_WIDTH;
   localparam logic [LW-1:0] LEVEL_FULL    = LW'(lbcc_pkg::DEFAULT_LEVEL);
   localparam logic [LW-1:0] LEVEL_QUARTER = LW'(lbcc_pkg::DEFAULT_LEVEL / 4);
   localparam logic [LW-1:0] LEVEL_HALF    = LW'(lbcc_pkg::DEFAULT_LEVEL / 2);
   localparam logic [LW-1:0] LEVEL_3QUART  = LW'((lbcc_pkg::DEFAULT_LEVEL * 3) / 4);

   localparam logic [2:0] COLOR_NONE    = 3'd0;
   localparam logic [2:0] COLOR_RED     = 3'd1;
   localparam logic [2:0] COLOR_MAGENTA = 3'd2;
   localparam logic [2:0] COLOR_BLUE    = 3'd3;
   localparam logic [2:0] COLOR_CYAN    = 3'd4;
   localparam logic [2:0] COLOR_GREEN   = 3'd5;
   localparam logic [2:0] COLOR_YELLOW  = 3'd6;

   localparam logic [2:0] LEVEL_CODE_ZERO    = 3'd1;
   localparam logic [2:0] LEVEL_CODE_QUARTER = 3'd2;
   localparam logic [2:0] LEVEL_CODE_HALF    = 3'd3;
   localparam logic [2:0] LEVEL_CODE_3QUART  = 3'd4;
   localparam logic [2:0] LEVEL_CODE_FULL    = 3'd5;

   localparam int PW = 12;   // sweep position
   localparam int SW = 14;   // signed pixel offset
   localparam logic [SW-2:0] PIXEL_LIMIT = (SW-1)'(lbcc_pkg::MAX_PIXELS);

   typedef struct packed {
      logic [LW-1:0] r;
      logic [LW-1:0] g;
      logic [LW-1:0] b;
   } rgb_type;

   function automatic rgb_type color_of(input logic [2:0] code, input logic [LW-1:0] full);
      logic [LW-1:0] half;
      rgb_type       c;
      half = full >> 1;
      c    = '0;
      unique case (code)
         COLOR_NONE:    c = '0;
         COLOR_RED:     c.r = full;
         COLOR_MAGENTA: begin c.r = half; c.b = half; end
         COLOR_BLUE:    c.b = full;
         COLOR_CYAN:    begin c.g = half; c.b = half; end
         COLOR_GREEN:   c.g = full;
         COLOR_YELLOW:  begin c.r = half; c.g = half; end
         default:       c = '0;
      endcase
      return c;
   endfunction

   // state
   logic              item_valid_ff, item_valid_in;
   lbcc_pkg::req_type item_ff, item_in;
   rgb_type           rgb_ff, rgb_in;
   logic [LW-1:0]     intensity_ff, intensity_in;
   logic [2:0]        color_ff, color_in;
   logic [PW-1:0]     position_ff, position_in;
   logic              backward_ff, backward_in;

   // datapath
   logic                 take;
   lbcc_pkg::push_type   result;
   logic [LW-1:0]        half;
   logic [LW-1:0]        level;
   logic                 level_ok;
   logic signed [SW-1:0] pos_s, strip_s, window_s, lead_s, tail_s;
   logic                 lead_ok, tail_ok;
   logic [PW-1:0]        period, pos_inc;
   rgb_type              rgb_prog;
   rgb_type              rgb_apply;

   assign half = intensity_ff >> 1;

   always_comb begin
      level_ok = 1'b1;
      level    = intensity_ff;
      unique case (item_ff.argument)
         LEVEL_CODE_ZERO:    level = '0;
         LEVEL_CODE_QUARTER: level = LEVEL_QUARTER;
         LEVEL_CODE_HALF:    level = LEVEL_HALF;
         LEVEL_CODE_3QUART:  level = LEVEL_3QUART;
         LEVEL_CODE_FULL:    level = LEVEL_FULL;
         default:            level_ok = 1'b0;
      endcase
   end

   // sweep geometry
   always_comb begin
      pos_s    = signed'({2'b00, position_ff});
      strip_s  = signed'({3'b000, cfg.strip_length});
      window_s = signed'({3'b000, cfg.window_length});
      if (backward_ff) begin
         lead_s = strip_s - pos_s;
         tail_s = lead_s + window_s;
      end else begin
         lead_s = pos_s;
         tail_s = pos_s - window_s;
      end
      lead_ok = !lead_s[SW-1] && (lead_s[SW-2:0] < {2'b00, cfg.strip_length})
                && (lead_s[SW-2:0] < PIXEL_LIMIT);
      tail_ok = !tail_s[SW-1] && (tail_s[SW-2:0] < {2'b00, cfg.strip_length})
                && (tail_s[SW-2:0] < PIXEL_LIMIT);
      period  = {1'b0, cfg.strip_length} + {1'b0, cfg.window_length};
      if (period == '0) begin
         period = PW'(1);
      end
      pos_inc = position_ff + PW'(1);
   end

   // color progression, chosen by which channels are zero
   always_comb begin
      rgb_prog = rgb_ff;
      unique case ({rgb_ff.r != '0, rgb_ff.g != '0, rgb_ff.b != '0})
         3'b000: rgb_prog.r = intensity_ff;
         3'b100: begin rgb_prog.r = half; rgb_prog.b = half; end
         3'b101: begin rgb_prog.r = '0; rgb_prog.b = intensity_ff; end
         3'b001: begin rgb_prog.g = half; rgb_prog.b = half; end
         3'b011: begin rgb_prog.g = intensity_ff; rgb_prog.b = '0; end
         3'b010: begin rgb_prog.g = half; rgb_prog.r = half; end
         3'b110: begin rgb_prog.g = '0; rgb_prog.r = intensity_ff; end
         3'b111: rgb_prog = rgb_ff;
      endcase
   end

   always_comb begin
      rgb_apply    = '0;
      result       = '0;
      rgb_in       = rgb_ff;
      intensity_in = intensity_ff;
      color_in     = color_ff;
      position_in  = position_ff;
      backward_in  = backward_ff;
      unique case (item_ff.command)
         lbcc_pkg::CMD_SELECT_COLOR: begin
            result.count = 2'd1;
            if (item_ff.argument == 3'd7) begin
               result.first.status = 1'b1;
            end else begin
               rgb_in   = color_of(item_ff.argument, intensity_ff);
               color_in = item_ff.argument;
            end
         end
         lbcc_pkg::CMD_SELECT_LEVEL: begin
            result.count = 2'd1;
            if (!level_ok) begin
               result.first.status = 1'b1;
            end else begin
               intensity_in = level;
               rgb_apply    = color_of(color_ff, level);
               rgb_in       = rgb_apply;
            end
         end
         lbcc_pkg::CMD_TICK: begin
            if (lead_ok) begin
               result.first.write_valid = 1'b1;
               result.first.pixel_index = lead_s[lbcc_pkg::INDEX_WIDTH-1:0];
               result.first.red_out     = rgb_ff.r;
               result.first.green_out   = rgb_ff.g;
               result.first.blue_out    = rgb_ff.b;
               result.first.show_frame  = !tail_ok;
               if (tail_ok) begin
                  result.second.write_valid = 1'b1;
                  result.second.pixel_index = tail_s[lbcc_pkg::INDEX_WIDTH-1:0];
                  result.second.show_frame  = 1'b1;
                  result.count              = 2'd2;
               end else begin
                  result.count = 2'd1;
               end
            end else if (tail_ok) begin
               result.first.write_valid = 1'b1;
               result.first.pixel_index = tail_s[lbcc_pkg::INDEX_WIDTH-1:0];
               result.first.show_frame  = 1'b1;
               result.count             = 2'd1;
            end else begin
               // nothing in the strip: still mark the frame
               result.first.show_frame = 1'b1;
               result.count            = 2'd1;
            end
            rgb_in = rgb_prog;
            if (pos_inc >= period) begin
               position_in = '0;
               backward_in = !backward_ff;
            end else begin
               position_in = pos_inc;
            end
         end
         lbcc_pkg::CMD_IGNORED: begin
            result.count = 2'd0;   // drop
         end
      endcase
   end

   assign take      = item_valid_ff && (result.count <= queue_status.room);
   assign req_ready = !item_valid_ff || take;

   always_comb begin
      push       = result;
      push.count = take ? result.count : 2'd0;
   end

   always_comb begin
      item_valid_in = item_valid_ff;
      item_in       = item_ff;
      if (req_ready) begin
         item_valid_in = req_valid;
         item_in       = req_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rgb_ff        <= '0;
         intensity_ff  <= LEVEL_FULL;
         color_ff      <= COLOR_RED;
         position_ff   <= '0;
         backward_ff   <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         if (take) begin
            rgb_ff       <= rgb_in;
            intensity_ff <= intensity_in;
            color_ff     <= color_in;
            position_ff  <= position_in;
            backward_ff  <= backward_in;
         end
      end
      item_ff <= item_in;
   end

   a_push_fits: assert property (@(posedge clock) disable iff (reset)
      push.count <= queue_status.room)
      else $error("push exceeds free queue slots");

   a_tick_result: assert property (@(posedge clock) disable iff (reset)
      (take && item_ff.command == lbcc_pkg::CMD_TICK) |-> push.count != 2'd0)
      else $error("tick gave no result");

endmodule

@@ src/led_bounce_color_cycler_core.sv @@
// ---------------------------------------------------------------------------
// led_bounce_color_cycler_core
// Bouncing lit window over an LED strip with a stepping color progression.
// ---------------------------------------------------------------------------
// An item is taken each cycle the queue has room for its results. Color
// and level commands give one result item, a sweep tick one or two (lead
// write, then tail write); the result side drains one item per cycle
// while the receiver is ready, via a two-entry queue, so two-pixel ticks
// are held back, the rest are not. The user must write strip and window
// lengths through the csr port only while the block is idle; not enforced.
module led_bounce_color_cycler_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  lbcc_pkg::req_type                   req_item,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output lbcc_pkg::rsp_type                   rsp_item,
   input  logic                                csr_write_enable,
   input  logic                                csr_index,
   input  logic [lbcc_pkg::CFG_WIDTH-1:0]      csr_write_data
);

   lbcc_pkg::cfg_type          cfg_ff, cfg_in;
   lbcc_pkg::push_type         push;
   lbcc_pkg::queue_status_type queue_status;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            lbcc_pkg::CSR_STRIP_LENGTH:  cfg_in.strip_length  = csr_write_data;
            lbcc_pkg::CSR_WINDOW_LENGTH: cfg_in.window_length = csr_write_data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.strip_length  <= lbcc_pkg::CFG_WIDTH'(60);
         cfg_ff.window_length <= lbcc_pkg::CFG_WIDTH'(5);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lbcc_engine u_engine (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_item     (req_item),
      .queue_status (queue_status),
      .push         (push)
   );

   lbcc_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .status    (queue_status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

endmodule

@@ sim/led_bounce_color_cycler_core_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// led_bounce_color_cycler_core_checker
// Watches the request, result and csr ports of the color cycler, predicts
// the pixel writes and status items that each accepted request causes, and
// compares every accepted result item field by field in arrival order.
// ---------------------------------------------------------------------------
module led_bounce_color_cycler_core_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  lbcc_pkg::req_type              req_item,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  lbcc_pkg::rsp_type              rsp_item,
   input  logic                           csr_write_enable,
   input  logic                           csr_index,
   input  logic [lbcc_pkg::CFG_WIDTH-1:0] csr_write_data,
   output int                             mismatch_count,
   output int                             pending_count
);

   localparam int CW = lbcc_pkg::CFG_WIDTH;
   localparam int LW = lbcc_pkg::LEVEL_WIDTH;

   localparam logic [2:0] COLOR_NONE    = 3'd0;
   localparam logic [2:0] COLOR_RED     = 3'd1;
   localparam logic [2:0] COLOR_MAGENTA = 3'd2;
   localparam logic [2:0] COLOR_BLUE    = 3'd3;
   localparam logic [2:0] COLOR_CYAN    = 3'd4;
   localparam logic [2:0] COLOR_GREEN   = 3'd5;
   localparam logic [2:0] COLOR_YELLOW  = 3'd6;

   localparam logic [2:0] LEVEL_ZERO          = 3'd1;
   localparam logic [2:0] LEVEL_QUARTER       = 3'd2;
   localparam logic [2:0] LEVEL_HALF          = 3'd3;
   localparam logic [2:0] LEVEL_THREE_QUARTER = 3'd4;
   localparam logic [2:0] LEVEL_FULL          = 3'd5;

   localparam int REPORT_LIMIT = 10;

   logic [CW-1:0] strip_len;
   logic [CW-1:0] window_len;
   logic [LW-1:0] red_lvl;
   logic [LW-1:0] green_lvl;
   logic [LW-1:0] blue_lvl;
   logic [LW-1:0] cur_intensity;
   logic [2:0]    cur_color;
   logic [11:0]   sweep_count;
   logic          going_back;

   lbcc_pkg::rsp_type expected_writes[$];

   function automatic lbcc_pkg::rsp_type status_item(input logic bad);
      lbcc_pkg::rsp_type r;
      r        = '0;
      r.status = bad;
      return r;
   endfunction

   function automatic bit on_strip(input int idx);
      return idx >= 0 && idx < int'(strip_len) && idx < lbcc_pkg::MAX_PIXELS;
   endfunction

   function automatic void load_color(input logic [2:0] code);
      logic [LW-1:0] full;
      logic [LW-1:0] half;
      full      = cur_intensity;
      half      = full >> 1;
      red_lvl   = '0;
      green_lvl = '0;
      blue_lvl  = '0;
      case (code)
         COLOR_NONE: ;
         COLOR_RED: red_lvl = full;
         COLOR_MAGENTA: begin
            red_lvl  = half;
            blue_lvl = half;
         end
         COLOR_BLUE: blue_lvl = full;
         COLOR_CYAN: begin
            green_lvl = half;
            blue_lvl  = half;
         end
         COLOR_GREEN: green_lvl = full;
         COLOR_YELLOW: begin
            red_lvl   = half;
            green_lvl = half;
         end
         default: ;
      endcase
      cur_color = code;
   endfunction

   // advance the color wheel by the zero pattern of the three levels
   function automatic void step_color_wheel();
      logic [LW-1:0] full;
      logic [LW-1:0] half;
      logic [2:0]    lit;
      full = cur_intensity;
      half = full >> 1;
      lit  = {red_lvl != 0, green_lvl != 0, blue_lvl != 0};
      case (lit)
         3'b000: red_lvl = full;
         3'b100: begin
            red_lvl  = half;
            blue_lvl = half;
         end
         3'b101: begin
            red_lvl  = '0;
            blue_lvl = full;
         end
         3'b001: begin
            green_lvl = half;
            blue_lvl  = half;
         end
         3'b011: begin
            green_lvl = full;
            blue_lvl  = '0;
         end
         3'b010: begin
            green_lvl = half;
            red_lvl   = half;
         end
         3'b110: begin
            green_lvl = '0;
            red_lvl   = full;
         end
         default: ;
      endcase
   endfunction

   function automatic void predict_tick();
      int                period;
      int                lead;
      int                tail;
      int                strip;
      int                win;
      int                count;
      bit                lead_in;
      bit                tail_in;
      lbcc_pkg::rsp_type r;
      strip  = int'(strip_len);
      win    = int'(window_len);
      count  = int'(sweep_count);
      period = strip + win;
      if (period == 0) begin
         period = 1;
      end
      if (!going_back) begin
         lead = count;
         tail = lead - win;
      end else begin
         lead = strip - count;
         tail = lead + win;
      end
      lead_in = on_strip(lead);
      tail_in = on_strip(tail);
      if (lead_in) begin
         r             = '0;
         r.write_valid = 1'b1;
         r.pixel_index = lbcc_pkg::INDEX_WIDTH'(lead);
         r.red_out     = red_lvl;
         r.green_out   = green_lvl;
         r.blue_out    = blue_lvl;
         r.show_frame  = !tail_in;
         expected_writes.push_back(r);
      end
      if (tail_in) begin
         r             = '0;
         r.write_valid = 1'b1;
         r.pixel_index = lbcc_pkg::INDEX_WIDTH'(tail);
         r.show_frame  = 1'b1;
         expected_writes.push_back(r);
      end
      if (!lead_in && !tail_in) begin
         r            = '0;
         r.show_frame = 1'b1;
         expected_writes.push_back(r);
      end
      step_color_wheel();
      sweep_count = sweep_count + 12'd1;
      if (int'(sweep_count) >= period) begin
         sweep_count = '0;
         going_back  = !going_back;
      end
   endfunction

   function automatic void predict_writes(input lbcc_pkg::req_type it);
      logic [LW-1:0] lv;
      logic          bad;
      bad = 1'b0;
      lv  = '0;
      case (it.command)
         lbcc_pkg::CMD_SELECT_COLOR: begin
            if (it.argument > COLOR_YELLOW) begin
               bad = 1'b1;
            end else begin
               load_color(it.argument);
            end
            expected_writes.push_back(status_item(bad));
         end
         lbcc_pkg::CMD_SELECT_LEVEL: begin
            case (it.argument)
               LEVEL_ZERO:          lv = '0;
               LEVEL_QUARTER:       lv = LW'(lbcc_pkg::DEFAULT_LEVEL / 4);
               LEVEL_HALF:          lv = LW'(lbcc_pkg::DEFAULT_LEVEL / 2);
               LEVEL_THREE_QUARTER: lv = LW'((lbcc_pkg::DEFAULT_LEVEL * 3) / 4);
               LEVEL_FULL:          lv = LW'(lbcc_pkg::DEFAULT_LEVEL);
               default:             bad = 1'b1;
            endcase
            if (!bad) begin
               cur_intensity = lv;
               load_color(cur_color);
            end
            expected_writes.push_back(status_item(bad));
         end
         lbcc_pkg::CMD_TICK: predict_tick();
         default: ;
      endcase
   endfunction

   function automatic void show_pair(input lbcc_pkg::rsp_type exp_item,
                                     input lbcc_pkg::rsp_type got_item);
      $display("  expected: wv=%0d idx=%0d rgb=%0d/%0d/%0d show=%0d status=%0d",
               exp_item.write_valid, exp_item.pixel_index, exp_item.red_out,
               exp_item.green_out, exp_item.blue_out, exp_item.show_frame,
               exp_item.status);
      $display("  actual:   wv=%0d idx=%0d rgb=%0d/%0d/%0d show=%0d status=%0d",
               got_item.write_valid, got_item.pixel_index, got_item.red_out,
               got_item.green_out, got_item.blue_out, got_item.show_frame,
               got_item.status);
   endfunction

   function automatic void check_result(input lbcc_pkg::rsp_type got_item);
      lbcc_pkg::rsp_type exp_item;
      if (expected_writes.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT) begin
            $display("[%0t] result item with nothing expected", $realtime);
            show_pair('0, got_item);
         end
      end else begin
         exp_item = expected_writes.pop_front();
         if (got_item.write_valid !== exp_item.write_valid ||
             got_item.pixel_index !== exp_item.pixel_index ||
             got_item.red_out     !== exp_item.red_out     ||
             got_item.green_out   !== exp_item.green_out   ||
             got_item.blue_out    !== exp_item.blue_out    ||
             got_item.show_frame  !== exp_item.show_frame  ||
             got_item.status      !== exp_item.status) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
               $display("[%0t] result item mismatch", $realtime);
               show_pair(exp_item, got_item);
            end
         end
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         strip_len      = CW'(60);
         window_len     = CW'(5);
         red_lvl        = '0;
         green_lvl      = '0;
         blue_lvl       = '0;
         cur_intensity  = LW'(lbcc_pkg::DEFAULT_LEVEL);
         cur_color      = COLOR_RED;
         sweep_count    = '0;
         going_back     = 1'b0;
         mismatch_count = 0;
         expected_writes.delete();
      end else begin
         if (csr_write_enable) begin
            if (csr_index == lbcc_pkg::CSR_STRIP_LENGTH) begin
               strip_len = csr_write_data;
            end else begin
               window_len = csr_write_data;
            end
         end
         if (req_valid && req_ready) begin
            predict_writes(req_item);
         end
         if (rsp_valid && rsp_ready) begin
            check_result(rsp_item);
         end
      end
      pending_count = expected_writes.size();
   end

endmodule

@@ sim/led_bounce_color_cycler_core_test.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// led_bounce_color_cycler_core_test
// Drives color, level, tick and ignored commands into the color cycler over
// a series of strip and window settings, with random gaps on both channels
// and long receiver stalls; the checker beside the block scores each result.
// ---------------------------------------------------------------------------
module led_bounce_color_cycler_core_test;

   localparam int CW              = lbcc_pkg::CFG_WIDTH;
   localparam int CYCLE_LIMIT     = 300000;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int SETTLE_CYCLES   = 16;
   localparam int PHASE_COUNT     = 24;
   localparam int ITEMS_PER_PHASE = 32;

   logic              clock            = 1'b0;
   logic              reset            = 1'b1;
   logic              req_valid        = 1'b0;
   logic              req_ready;
   lbcc_pkg::req_type req_item         = '0;
   logic              rsp_valid;
   logic              rsp_ready        = 1'b0;
   lbcc_pkg::rsp_type rsp_item;
   logic              csr_write_enable = 1'b0;
   logic              csr_index        = lbcc_pkg::CSR_STRIP_LENGTH;
   logic [CW-1:0]     csr_write_data   = '0;

   int   mismatch_count;
   int   pending_count;
   int   send_idle_pct   = 0;
   int   recv_idle_pct   = 0;
   int   cycle_count     = 0;
   logic hold_off_toggle = 1'b0;

   led_bounce_color_cycler_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_item         (req_item),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_item         (rsp_item),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   led_bounce_color_cycler_core_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_item         (req_item),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_item         (rsp_item),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .mismatch_count   (mismatch_count),
      .pending_count    (pending_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("led_bounce_color_cycler_core_test: done, errors");
      $finish;
   end

   // result side: random back-pressure, plus a long hold-off on request
   initial begin
      logic hold_seen;
      int   hold_left;
      hold_seen = 1'b0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_off_toggle != hold_seen) begin
            hold_seen = hold_off_toggle;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   function automatic lbcc_pkg::req_type make_item(input logic [1:0] cmd,
                                                   input logic [2:0] arg);
      lbcc_pkg::req_type it;
      it.command  = cmd;
      it.argument = arg;
      return it;
   endfunction

   function automatic lbcc_pkg::req_type random_item();
      int pick;
      pick = $urandom_range(99);
      if (pick < 70) begin
         return make_item(lbcc_pkg::CMD_TICK, 3'($urandom_range(7)));
      end else if (pick < 82) begin
         return make_item(lbcc_pkg::CMD_SELECT_COLOR, 3'($urandom_range(7)));
      end else if (pick < 94) begin
         return make_item(lbcc_pkg::CMD_SELECT_LEVEL, 3'($urandom_range(7)));
      end
      return make_item(lbcc_pkg::CMD_IGNORED, 3'($urandom_range(7)));
   endfunction

   // called at a clock edge; returns at the edge that accepts the item
   task automatic offer_item(input lbcc_pkg::req_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= it;
      do begin
         @(posedge clock);
      end while (!req_ready);
   endtask

   // hold the sender until every expected item is back, then let the block settle
   task automatic drain_results();
      req_valid <= 1'b0;
      do begin
         @(posedge clock);
      end while (pending_count != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_lengths(input logic [CW-1:0] strip,
                                input logic [CW-1:0] window);
      csr_write_enable <= 1'b1;
      csr_index        <= lbcc_pkg::CSR_STRIP_LENGTH;
      csr_write_data   <= strip;
      @(posedge clock);
      csr_index        <= lbcc_pkg::CSR_WINDOW_LENGTH;
      csr_write_data   <= window;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic choose_lengths(input int phase, output logic [CW-1:0] strip,
                                 output logic [CW-1:0] window);
      case (phase)
         0:  begin strip = 11'd1;    window = 11'd0;    end
         1:  begin strip = 11'd0;    window = 11'd0;    end
         2:  begin strip = 11'd0;    window = 11'd1;    end
         3:  begin strip = 11'd3;    window = 11'd1;    end
         4:  begin strip = 11'd4;    window = 11'd0;    end
         5:  begin strip = 11'd1024; window = 11'd2047; end
         6:  begin strip = 11'd2047; window = 11'd2047; end
         7:  begin strip = 11'd8;    window = 11'd3;    end
         8:  begin strip = 11'd5;    window = 11'd12;   end
         9:  begin strip = 11'd1;    window = 11'd1024; end
         10: begin strip = 11'd1000; window = 11'd1;    end
         11: begin strip = 11'd60;   window = 11'd5;    end
         default: begin
            // mostly short strips so passes turn around often
            if ($urandom_range(7) == 0) begin
               strip = 11'($urandom_range(2047));
            end else begin
               strip = 11'($urandom_range(12));
            end
            if ($urandom_range(7) == 0) begin
               window = 11'($urandom_range(2047));
            end else begin
               window = 11'($urandom_range(8));
            end
         end
      endcase
   endtask

   initial begin
      logic [CW-1:0] strip;
      logic [CW-1:0] window;
      send_idle_pct = 7;
      recv_idle_pct = 64;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // every color code, then every level code, with ticks between
      for (int a = 0; a < 8; a++) begin
         offer_item(make_item(lbcc_pkg::CMD_SELECT_COLOR, 3'(a)));
      end
      repeat (2) offer_item(make_item(lbcc_pkg::CMD_TICK, 3'd0));
      for (int a = 0; a < 8; a++) begin
         offer_item(make_item(lbcc_pkg::CMD_SELECT_LEVEL, 3'(a)));
      end
      repeat (4) offer_item(make_item(lbcc_pkg::CMD_TICK, 3'd7));
      offer_item(make_item(lbcc_pkg::CMD_IGNORED, 3'd7));
      offer_item(make_item(lbcc_pkg::CMD_SELECT_COLOR, 3'd0));
      offer_item(make_item(lbcc_pkg::CMD_TICK, 3'd5));
      drain_results();

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         if (phase < PHASE_COUNT / 3) begin
            send_idle_pct = 7;
            recv_idle_pct = 64;
         end else if (phase < (2 * PHASE_COUNT) / 3) begin
            send_idle_pct = 64;
            recv_idle_pct = 7;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         choose_lengths(phase, strip, window);
         write_lengths(strip, window);
         if (phase == 3 || phase == 12 || phase == 20) begin
            hold_off_toggle <= ~hold_off_toggle;
         end
         repeat (ITEMS_PER_PHASE) offer_item(random_item());
         drain_results();
      end

      if (mismatch_count == 0 && pending_count == 0) begin
         $display("led_bounce_color_cycler_core_test: done, clean");
      end else begin
         $display("led_bounce_color_cycler_core_test: done, errors");
      end
      $finish;
   end

endmodule
